// ----- rtl/bba_pkg.sv -----
// bba_pkg: shared types, codes and defaults for the block bitmap allocator
// used by every module under rtl/ except bba_ram, no dependencies
package bba_pkg;

	// default sizing of the bitmap
	localparam int MAX_BLOCKS_DEF = 32768;
	localparam int WORD_BITS_DEF  = 64;

	// fixed field widths
	localparam int COUNT_W = 16;
	localparam int IDX_W   = 15;
	localparam int BASE_W  = COUNT_W + 1;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 16'd32768;

	// request opcodes
	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_MARK  = 2'd2;
	localparam logic [1:0] OP_TEST  = 2'd3;

	// response status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [IDX_W-1:0] blk_idx;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] allocated_index;
		logic             was_used;
	} rsp_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_MODIFY,
		S_SCAN,
		S_DONE
	} state_t;

endpackage

// ----- rtl/bba_ram.sv -----
// bba_ram: generic single-port ram, one write or read per cycle, registered read
// no dependencies
module bba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                           wdata,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read on the same address
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ----- rtl/bba_find_unit.sv -----
// bba_find_unit: lowest free bit search over one bitmap word, limited to the managed count
// depends on bba_pkg
module bba_find_unit #(
	parameter int WORD_BITS = bba_pkg::WORD_BITS_DEF
) (
	input  logic [WORD_BITS-1:0]               word,
	input  logic [bba_pkg::BASE_W-1:0]         base,
	input  logic [bba_pkg::COUNT_W-1:0]        cnt,
	output logic                               found,
	output logic [$clog2(WORD_BITS)-1:0]       pos,
	output logic [WORD_BITS-1:0]               onehot
);

	localparam int BIT_W = $clog2(WORD_BITS);

	logic [bba_pkg::BASE_W-1:0] remaining;
	logic [WORD_BITS-1:0]       mask;
	logic [WORD_BITS-1:0]       free_bits;

	// bits of this word that still lie below the count
	assign remaining = bba_pkg::BASE_W'(cnt) - base;

	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			mask[b] = bba_pkg::BASE_W'(b) < remaining;
		end
	end

	// isolate the lowest free bit
	assign free_bits = ~word & mask;
	assign onehot    = free_bits & (~free_bits + WORD_BITS'(1));
	assign found     = |free_bits;

	// encode its position
	always_comb begin
		pos = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			if (onehot[b]) begin
				pos = pos | BIT_W'(b);
			end
		end
	end

endmodule

// ----- rtl/bba_ctrl.sv -----
// bba_ctrl: request sequencer, index split, word scan and response register
// depends on bba_pkg; drives bba_ram and bba_find_unit
module bba_ctrl #(
	parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
	parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [bba_pkg::COUNT_W-1:0]            cnt,
	input  logic                                   req_valid,
	output logic                                   req_ready,
	input  bba_pkg::req_t                          req,
	output logic                                   rsp_valid,
	input  logic                                   rsp_ready,
	output bba_pkg::rsp_t                          rsp,
	output logic                                   ram_we,
	output logic [((MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS > 1 ?
		$clog2((MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS) : 1)-1:0] ram_addr,
	output logic [WORD_BITS-1:0]                   ram_wdata,
	input  logic [WORD_BITS-1:0]                   ram_rdata,
	output logic [bba_pkg::BASE_W-1:0]             find_base,
	input  logic                                   find_found,
	input  logic [$clog2(WORD_BITS)-1:0]           find_pos,
	input  logic [WORD_BITS-1:0]                   find_onehot
);

	localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int IW        = bba_pkg::IDX_W;
	localparam int BW        = bba_pkg::BASE_W;

	bba_pkg::state_t state_q, state_d;

	logic [1:0]                   op_q;
	logic [IW-1:0]                sh_q;
	logic [AW-1:0]                clr_q;
	logic [AW-1:0]                rd_addr_q;
	logic [BW-1:0]                rd_base_q;
	logic                         rd_valid_s1;
	logic [AW-1:0]                addr_s1;
	logic [BW-1:0]                base_s1;
	bba_pkg::rsp_t                res_q;
	bba_pkg::rsp_t                rsp_q;
	logic                         rsp_valid_q;

	logic                         accept;
	logic                         idx_range;
	logic                         issue;
	logic                         scan_hit;
	logic                         scan_full;
	logic                         clr_last;
	logic                         out_free;
	logic [WORD_BITS-1:0]         bit_sel;
	logic [AW-1:0]                word_addr;

	// status of the current step
	assign accept    = req_valid && req_ready;
	assign idx_range = bba_pkg::COUNT_W'(req.blk_idx) >= cnt;
	assign scan_hit  = rd_valid_s1 && find_found;
	assign issue     = (state_q == bba_pkg::S_SCAN) && (BW'(cnt) > rd_base_q) && !scan_hit;
	assign scan_full = (state_q == bba_pkg::S_SCAN) && !issue && !scan_hit;
	assign clr_last  = clr_q == AW'(MAP_WORDS - 1);
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign find_base = base_s1;

	// word address and bit position of the index
	assign word_addr = AW'(sh_q >> BIT_W);
	assign bit_sel   = WORD_BITS'(1) << sh_q[BIT_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bba_pkg::S_CLEAR: begin
				if (clr_last) begin
					state_d = bba_pkg::S_IDLE;
				end
			end
			bba_pkg::S_IDLE: begin
				if (req_valid) begin
					if (req.opcode == bba_pkg::OP_ALLOC) begin
						state_d = bba_pkg::S_SCAN;
					end else if (idx_range) begin
						state_d = bba_pkg::S_DONE;
					end else begin
						state_d = bba_pkg::S_READ;
					end
				end
			end
			bba_pkg::S_READ:   state_d = bba_pkg::S_MODIFY;
			bba_pkg::S_MODIFY: state_d = bba_pkg::S_DONE;
			bba_pkg::S_SCAN: begin
				if (scan_hit || scan_full) begin
					state_d = bba_pkg::S_DONE;
				end
			end
			bba_pkg::S_DONE: begin
				if (out_free) begin
					state_d = bba_pkg::S_IDLE;
				end
			end
			default: state_d = bba_pkg::S_IDLE;
		endcase
	end

	// ram port and handshake outputs
	always_comb begin
		req_ready = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = rd_addr_q;
		ram_wdata = '0;
		case (state_q)
			bba_pkg::S_CLEAR: begin
				ram_we   = 1'b1;
				ram_addr = clr_q;
			end
			bba_pkg::S_IDLE: begin
				req_ready = 1'b1;
			end
			bba_pkg::S_READ: begin
				ram_addr = word_addr;
			end
			bba_pkg::S_MODIFY: begin
				ram_addr = word_addr;
				ram_we   = op_q != bba_pkg::OP_TEST;
				if (op_q == bba_pkg::OP_FREE) begin
					ram_wdata = ram_rdata & ~bit_sel;
				end else begin
					ram_wdata = ram_rdata | bit_sel;
				end
			end
			bba_pkg::S_SCAN: begin
				if (scan_hit) begin
					ram_we    = 1'b1;
					ram_addr  = addr_s1;
					ram_wdata = ram_rdata | find_onehot;
				end
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bba_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// control counters and scan pipeline flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			rd_addr_q   <= '0;
			rd_base_q   <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			case (state_q)
				bba_pkg::S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
				end
				bba_pkg::S_IDLE: begin
					rd_addr_q   <= '0;
					rd_base_q   <= '0;
					rd_valid_s1 <= 1'b0;
				end
				bba_pkg::S_SCAN: begin
					rd_valid_s1 <= issue;
					if (issue) begin
						rd_addr_q <= rd_addr_q + AW'(1);
						rd_base_q <= rd_base_q + BW'(WORD_BITS);
					end
				end
				default: begin
					rd_valid_s1 <= 1'b0;
				end
			endcase
		end
	end

	// request payload and result
	always_ff @(posedge clk) begin
		case (state_q)
			bba_pkg::S_IDLE: begin
				if (accept) begin
					op_q  <= req.opcode;
					sh_q  <= req.blk_idx;
					res_q.status          <= bba_pkg::ST_RANGE;
					res_q.allocated_index <= '0;
					res_q.was_used        <= req.opcode == bba_pkg::OP_TEST;
				end
			end
			bba_pkg::S_MODIFY: begin
				res_q.status          <= bba_pkg::ST_OK;
				res_q.allocated_index <= '0;
				res_q.was_used        <= (op_q == bba_pkg::OP_TEST) &&
					ram_rdata[sh_q[BIT_W-1:0]];
			end
			bba_pkg::S_SCAN: begin
				if (issue) begin
					addr_s1 <= rd_addr_q;
					base_s1 <= rd_base_q;
				end
				if (scan_hit) begin
					res_q.status          <= bba_pkg::ST_OK;
					res_q.allocated_index <= IW'(base_s1 + BW'(find_pos));
					res_q.was_used        <= 1'b0;
				end else if (scan_full) begin
					res_q.status          <= bba_pkg::ST_FULL;
					res_q.allocated_index <= '0;
					res_q.was_used        <= 1'b0;
				end
			end
			default: begin
				op_q <= op_q;
			end
		endcase
	end

	// response output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == bba_pkg::S_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == bba_pkg::S_DONE && out_free) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- rtl/block_bitmap_allocator_top.sv -----
// block_bitmap_allocator_top: first-fit used/free bitmap over the storage blocks
// depends on bba_pkg, bba_ram, bba_find_unit, bba_ctrl
// Requests come in on req (opcode, blk_idx) with req_valid/req_ready, and
// each one gives exactly one response on rsp (status, allocated_index, was_used)
// with rsp_valid/rsp_ready. cfg_we/cfg_wdata write the managed block count,
// which saturates at MAX_BLOCKS; write it only while no request is in flight.
// One request is worked on at a time and req_ready is low meanwhile; with the
// receiver ready the next transfer can come in the same cycle that rsp_valid rises.
// Work per request:
//   allocate: the scan reads one bitmap word per cycle, at most
//     ceil(count / WORD_BITS) words, through the single ram port and one
//     shared find unit
//   free, mark, test in range: word and bit come from the index by shift and
//     mask, then one ram read and, for free and mark, one read-modify-write
//   free, mark, test at or above the count: the map is not touched
// After reset the bitmap ram is swept to zero, one word per cycle over all MAP_WORDS
// words; req_ready stays low during the sweep, config writes are taken. A finished
// response sits in an output register; while rsp_ready is low the next request
// is still taken and worked on, and it waits at its end until the output
// register frees up.
module block_bitmap_allocator_top #(
	parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
	parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  bba_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output bba_pkg::rsp_t                 rsp,
	input  logic                          cfg_we,
	input  logic [bba_pkg::COUNT_W-1:0]   cfg_wdata
);

	localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int CAP       = MAX_BLOCKS > 65535 ? 65535 : MAX_BLOCKS;

	logic [bba_pkg::COUNT_W-1:0] count_q;
	logic [bba_pkg::COUNT_W-1:0] cnt;
	logic                        ram_we;
	logic [AW-1:0]               ram_addr;
	logic [WORD_BITS-1:0]        ram_wdata;
	logic [WORD_BITS-1:0]        ram_rdata;
	logic [bba_pkg::BASE_W-1:0]  find_base;
	logic                        find_found;
	logic [BIT_W-1:0]            find_pos;
	logic [WORD_BITS-1:0]        find_onehot;

	// block count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= bba_pkg::COUNT_RESET;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	// count saturated to the bitmap capacity
	assign cnt = (count_q > bba_pkg::COUNT_W'(CAP)) ? bba_pkg::COUNT_W'(CAP) : count_q;

	bba_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	bba_find_unit #(
		.WORD_BITS (WORD_BITS)
	) u_find (
		.word   (ram_rdata),
		.base   (find_base),
		.cnt    (cnt),
		.found  (find_found),
		.pos    (find_pos),
		.onehot (find_onehot)
	);

	bba_ctrl #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.WORD_BITS  (WORD_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cnt         (cnt),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.ram_we      (ram_we),
		.ram_addr    (ram_addr),
		.ram_wdata   (ram_wdata),
		.ram_rdata   (ram_rdata),
		.find_base   (find_base),
		.find_found  (find_found),
		.find_pos    (find_pos),
		.find_onehot (find_onehot)
	);

endmodule

// ----- rtl/bba_checker.sv -----
// bba_checker: port-level checks of the block bitmap allocator, bound to the top level
// depends on bba_pkg and block_bitmap_allocator_top
module bba_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input bba_pkg::req_t                 req,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input bba_pkg::rsp_t                 rsp
);

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// a waiting request holds
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("request changed while waiting");

	// one request at a time: busy right after a transfer
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// no reserved status code, and a failed search grants nothing
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status <= bba_pkg::ST_RANGE) &&
			(rsp.status != bba_pkg::ST_FULL || (rsp.allocated_index == '0 && !rsp.was_used)))
		else $error("bad full or reserved status");

	// a range error or a used flag never carries a granted block
	a_range_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == bba_pkg::ST_RANGE || rsp.was_used) |->
			rsp.allocated_index == '0)
		else $error("granted index with range error or test");

endmodule

bind block_bitmap_allocator_top bba_checker u_bba_checker (.*);

// ----- verif/tb_block_bitmap_allocator_top.sv -----
// tb_block_bitmap_allocator_top: self-checking testbench for the block bitmap allocator
// depends on bba_pkg and block_bitmap_allocator_top; runs directed then random requests
// against an in-bench first-fit bitmap model with bursty sender and stalling receiver
module tb_block_bitmap_allocator_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WB             = bba_pkg::WORD_BITS_DEF;
	localparam int MAP_WORDS      = bba_pkg::MAX_BLOCKS_DEF / bba_pkg::WORD_BITS_DEF;
	localparam int IW             = bba_pkg::IDX_W;
	localparam int CW             = bba_pkg::COUNT_W;
	localparam int WATCHDOG_LIMIT = 8000;
	localparam int DRAIN_CYCLES   = 600;
	localparam int RANDOM_ITEMS   = 1150;

	// first-fit bitmap model and queue of awaited responses
	class alloc_scoreboard;
		logic [WB-1:0]      used_words [MAP_WORDS];
		logic [CW-1:0]      count_reg;
		bba_pkg::rsp_t      awaited_responses [$];
		int unsigned        granted_blocks [$];
		int                 errors;

		function new();
			foreach (used_words[w])
				used_words[w] = '0;
			count_reg = bba_pkg::COUNT_RESET;
			errors = 0;
		endfunction

		function void set_count(input logic [CW-1:0] v);
			count_reg = v;
		endfunction

		// count saturates at capacity
		function int unsigned managed();
			if (count_reg > bba_pkg::MAX_BLOCKS_DEF)
				return bba_pkg::MAX_BLOCKS_DEF;
			return 32'(count_reg);
		endfunction

		function bit is_used(input int unsigned blk);
			return used_words[blk / WB][blk % WB];
		endfunction

		function void put_bit(input int unsigned blk, input bit v);
			used_words[blk / WB][blk % WB] = v;
		endfunction

		function int pending();
			return awaited_responses.size();
		endfunction

		// apply one accepted request and queue the response it must produce
		function void serve_request(input bba_pkg::req_t r);
			bba_pkg::rsp_t e;
			int unsigned   cnt;
			int unsigned   i;
			cnt = managed();
			e = '0;
			if (r.opcode == bba_pkg::OP_ALLOC) begin
				e.status = bba_pkg::ST_FULL;
				for (i = 0; i < cnt; i++) begin
					if (!is_used(i)) begin
						put_bit(i, 1'b1);
						e.allocated_index = i[IW-1:0];
						e.status = bba_pkg::ST_OK;
						granted_blocks.push_back(i);
						break;
					end
				end
			end else if (r.blk_idx >= cnt) begin
				e.status = bba_pkg::ST_RANGE;
				if (r.opcode == bba_pkg::OP_TEST)
					e.was_used = 1'b1;
			end else if (r.opcode == bba_pkg::OP_FREE) begin
				put_bit(32'(r.blk_idx), 1'b0);
			end else if (r.opcode == bba_pkg::OP_MARK) begin
				put_bit(32'(r.blk_idx), 1'b1);
			end else begin
				e.was_used = is_used(32'(r.blk_idx));
			end
			awaited_responses.push_back(e);
		endfunction

		// compare one accepted response with the oldest awaited one
		function void check_response(input bba_pkg::rsp_t got);
			bba_pkg::rsp_t e;
			if (awaited_responses.size() == 0) begin
				$error("response with none awaited: status %0d index %0d was_used %0d",
					got.status, got.allocated_index, got.was_used);
				errors++;
				return;
			end
			e = awaited_responses.pop_front();
			if (got.status !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, got.status);
				errors++;
			end
			if (got.allocated_index !== e.allocated_index) begin
				$error("allocated_index: expected %0d, actual %0d",
					e.allocated_index, got.allocated_index);
				errors++;
			end
			if (got.was_used !== e.was_used) begin
				$error("was_used: expected %0d, actual %0d", e.was_used, got.was_used);
				errors++;
			end
		endfunction

		function void flag_leftovers();
			if (awaited_responses.size() != 0) begin
				$error("%0d responses never arrived", awaited_responses.size());
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_ready;
	bba_pkg::req_t      req;
	logic               rsp_valid;
	logic               rsp_ready;
	bba_pkg::rsp_t      rsp;
	logic               cfg_we;
	logic [CW-1:0]      cfg_wdata;

	alloc_scoreboard sb = new();

	int burst_left;
	int rx_mode;
	int rx_left;
	int rx_tick;
	int quiet_cycles;

	block_bitmap_allocator_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// clock, 4 ns period
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// response side: check each transfer, stall on a changing pattern
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_response(rsp);
		if (rx_left == 0) begin
			rx_mode = $urandom_range(3);
			rx_left = $urandom_range(200, 20);
		end
		rx_left--;
		rx_tick++;
		case (rx_mode)
			0: rsp_ready <= 1'b1;
			1: rsp_ready <= 1'($urandom_range(1));
			2: rsp_ready <= (rx_tick % 40) < 3;
			default: rsp_ready <= ($urandom_range(7) != 0);
		endcase
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// present one request and hold it until its transfer; valid stays high
	task automatic send_request(input logic [1:0] op, input logic [IW-1:0] idx);
		bba_pkg::req_t r;
		r.opcode = op;
		r.blk_idx = idx;
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		sb.serve_request(r);
	endtask

	// bursty sender: a random gap before each burst
	task automatic send_bursty(input logic [1:0] op, input logic [IW-1:0] idx);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(12, 1);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(24, 1);
		end
		burst_left--;
		send_request(op, idx);
	endtask

	// hold off until every awaited response has come back
	task automatic drain_responses();
		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_count(input logic [CW-1:0] v);
		drain_responses();
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_count(v);
	endtask

	// index mix: mostly in range, some boundaries, some anywhere
	function automatic logic [IW-1:0] pick_index(input int unsigned cnt);
		logic [IW-1:0] idx;
		int unsigned   sel;
		sel = $urandom_range(9);
		idx = IW'($urandom);
		if (sel <= 5 && cnt > 0) begin
			idx = IW'($urandom_range(cnt - 1));
		end else if (sel == 6) begin
			case ($urandom_range(3))
				0: idx = '0;
				1: idx = IW'(cnt - 1);
				2: idx = IW'(cnt);
				default: idx = '1;
			endcase
		end
		return idx;
	endfunction

	// a block granted earlier, so frees mostly undo real allocations
	function automatic logic [IW-1:0] pick_granted(input int unsigned cnt);
		int unsigned k;
		int unsigned blk;
		if (sb.granted_blocks.size() == 0)
			return pick_index(cnt);
		k = $urandom_range(sb.granted_blocks.size() - 1);
		blk = sb.granted_blocks[k];
		sb.granted_blocks.delete(k);
		return IW'(blk);
	endfunction

	task automatic random_phase(input int items);
		int unsigned   r;
		logic [1:0]    op;
		logic [IW-1:0] idx;
		repeat (items) begin
			r = $urandom_range(99);
			if (r < 35) begin
				op = bba_pkg::OP_ALLOC;
				idx = IW'($urandom);
			end else if (r < 60) begin
				op = bba_pkg::OP_FREE;
				idx = ($urandom_range(9) < 6) ? pick_granted(sb.managed())
					: pick_index(sb.managed());
			end else if (r < 72) begin
				op = bba_pkg::OP_MARK;
				idx = pick_index(sb.managed());
			end else begin
				op = bba_pkg::OP_TEST;
				idx = pick_index(sb.managed());
			end
			send_bursty(op, idx);
			if ($urandom_range(39) == 0)
				drain_responses();
		end
	endtask

	logic [CW-1:0] phase_counts [16] = '{
		16'd1, 16'd2, 16'd63, 16'd64, 16'd65, 16'd200, 16'd32768, 16'd0,
		16'd777, 16'd65535, 16'd128, 16'd3, 16'd32767, 16'd5000, 16'd100, 16'd1000
	};

	initial begin
		req_valid <= 1'b0;
		req <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		arst_n <= 1'b0;
		burst_left = 0;
		rx_mode = 0;
		rx_left = 0;
		rx_tick = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: default count, first fit from an empty map
		send_request(bba_pkg::OP_ALLOC, '0);
		send_request(bba_pkg::OP_ALLOC, 15'd77);
		send_request(bba_pkg::OP_ALLOC, '1);
		send_request(bba_pkg::OP_TEST, 15'd0);
		send_request(bba_pkg::OP_TEST, 15'd32767);
		send_request(bba_pkg::OP_MARK, 15'd32767);
		send_request(bba_pkg::OP_TEST, 15'd32767);
		send_request(bba_pkg::OP_FREE, 15'd1);
		send_request(bba_pkg::OP_ALLOC, '0);
		send_request(bba_pkg::OP_FREE, 15'd0);

		// small count: fill up, no free block, out of range requests
		write_count(16'd4);
		send_request(bba_pkg::OP_ALLOC, '0);
		send_request(bba_pkg::OP_ALLOC, '0);
		send_request(bba_pkg::OP_ALLOC, '0);
		send_request(bba_pkg::OP_TEST, 15'd5);
		send_request(bba_pkg::OP_FREE, 15'd4);
		send_request(bba_pkg::OP_MARK, 15'd32767);
		send_request(bba_pkg::OP_FREE, 15'd2);
		send_request(bba_pkg::OP_ALLOC, '0);

		// zero count: nothing managed
		write_count(16'd0);
		send_request(bba_pkg::OP_ALLOC, '0);
		send_request(bba_pkg::OP_TEST, 15'd0);
		send_request(bba_pkg::OP_FREE, 15'd0);

		// count above capacity saturates, high bit kept while hidden
		write_count(16'd65535);
		send_request(bba_pkg::OP_TEST, 15'd32767);

		// single block
		write_count(16'd1);
		send_request(bba_pkg::OP_ALLOC, '0);
		send_request(bba_pkg::OP_FREE, 15'd0);
		send_request(bba_pkg::OP_ALLOC, '0);

		// random phases over a spread of counts
		foreach (phase_counts[p]) begin
			write_count(phase_counts[p]);
			random_phase(RANDOM_ITEMS / 16 + int'($urandom_range(8)) - 4);
		end

		// wait out every response, then a quiet tail
		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.flag_leftovers();
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
